/* rtl/core/sacbpv_pkg.sv */
package sacbpv_pkg;

    // Default geometry of the cache.
    localparam int SETS_DEF        = 64;
    localparam int WAYS_DEF        = 4;
    localparam int BLOCK_WORDS_DEF = 4;

    // Fixed field widths.
    localparam int ADDR_W     = 32;
    localparam int WORD_W     = 64;
    localparam int BP_W       = 5;
    localparam int STATUS_W   = 3;
    localparam int FILL_WORDS = 4;

    // Request tdata layout, lowest bit first.
    localparam int ADDR_LSB  = 0;
    localparam int BP_LSB    = ADDR_LSB + ADDR_W;
    localparam int FILL_LSB  = BP_LSB + BP_W;
    localparam int IN_USED_W = FILL_LSB + FILL_WORDS * WORD_W;
    localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = WORD_W;

    // Opcodes carried in the request tuser.
    localparam logic OP_READ = 1'b0;
    localparam logic OP_FILL = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_READ_HIT  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_READ_MISS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FILLED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic commit;
        logic clear_step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/core/sacbpv_ctrl.sv */
module sacbpv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sacbpv_pkg::dp_stat_t stat,
    output sacbpv_pkg::dp_cmd_t  cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                // The set row is written back only when the result can be stored.
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

/* rtl/core/sacbpv_dp.sv */
module sacbpv_dp #(
    parameter int SETS        = sacbpv_pkg::SETS_DEF,
    parameter int WAYS        = sacbpv_pkg::WAYS_DEF,
    parameter int BLOCK_WORDS = sacbpv_pkg::BLOCK_WORDS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sacbpv_pkg::dp_cmd_t                   cmd,
    output sacbpv_pkg::dp_stat_t                  stat,
    input  logic [sacbpv_pkg::IN_DATA_W-1:0]      in_data,
    input  logic                                  in_user,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sacbpv_pkg::OUT_DATA_W-1:0]     out_data,
    output logic [sacbpv_pkg::STATUS_W-1:0]       out_user
);

    localparam int ADDR_W = sacbpv_pkg::ADDR_W;
    localparam int WORD_W = sacbpv_pkg::WORD_W;
    localparam int BP_W   = sacbpv_pkg::BP_W;
    localparam int OB     = $clog2(BLOCK_WORDS);
    localparam int IB     = $clog2(SETS);
    localparam int OB_W   = (OB > 0) ? OB : 1;
    localparam int IB_W   = (IB > 0) ? IB : 1;
    localparam int TAG_W  = ADDR_W - OB - IB;

    // Incoming request fields.
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] in_set_full;
    logic              in_range;
    logic [IB_W-1:0]   in_set;
    logic [OB_W-1:0]   in_offset;
    logic [TAG_W-1:0]  in_tag;
    logic [BLOCK_WORDS-1:0][WORD_W-1:0] in_block;

    // Held request.
    logic              req_op_reg;
    logic              req_range_reg;
    logic [IB_W-1:0]   req_set_reg;
    logic [OB_W-1:0]   req_offset_reg;
    logic [TAG_W-1:0]  req_tag_reg;
    logic [BP_W-1:0]   req_bp_reg;
    logic [BLOCK_WORDS-1:0][WORD_W-1:0] req_block_reg;

    // Set row memories and their registered read data.
    logic [WAYS-1:0]                               valid_mem [SETS];
    logic [WAYS-1:0][TAG_W-1:0]                    tag_mem   [SETS];
    logic [WAYS-1:0][BP_W-1:0]                     prio_mem  [SETS];
    logic [WAYS-1:0][BLOCK_WORDS-1:0][WORD_W-1:0]  data_mem  [SETS];

    logic [WAYS-1:0]                               rd_valid_reg;
    logic [WAYS-1:0][TAG_W-1:0]                    rd_tag_reg;
    logic [WAYS-1:0][BP_W-1:0]                     rd_prio_reg;
    logic [WAYS-1:0][BLOCK_WORDS-1:0][WORD_W-1:0]  rd_data_reg;

    logic [IB_W-1:0] clr_idx_reg;

    // Lookup results.
    logic [WAYS-1:0] tag_eq;
    logic [WAYS-1:0] hit_vec;
    logic [WAYS-1:0] hit_oh;
    logic [WAYS-1:0] prefix_vec;
    logic [WAYS-1:0] present_vec;
    logic [WAYS-1:0] present_oh;
    logic [WAYS-1:0] empty_vec;
    logic [WAYS-1:0] empty_oh;
    logic [WAYS-1:0] best_vec;
    logic [WAYS-1:0] best_oh;
    logic [WAYS-1:0] chosen_oh;
    logic [WAYS-1:0] fill_oh;
    logic            present_any;
    logic            chosen_any;

    logic [WAYS-1:0]                               valid_next;
    logic [WAYS-1:0][TAG_W-1:0]                    tag_next;
    logic [WAYS-1:0][BP_W-1:0]                     prio_next;
    logic [WAYS-1:0][BLOCK_WORDS-1:0][WORD_W-1:0]  data_next;

    logic                                   row_we;
    logic                                   valid_we;
    logic [IB_W-1:0]                        wr_set;
    logic [WAYS-1:0]                        valid_wdata;
    logic                                   rd_en;
    logic [sacbpv_pkg::STATUS_W-1:0]        status_next;
    logic [WORD_W-1:0]                      word_next;

    logic                                   out_valid_reg;
    logic [sacbpv_pkg::STATUS_W-1:0]        out_status_reg;
    logic [WORD_W-1:0]                      out_word_reg;

    // Address split: offset, set index, tag from the low end.
    always_comb
    begin
        in_addr     = in_data[sacbpv_pkg::ADDR_LSB +: ADDR_W];
        in_set_full = (in_addr >> OB) & ((32'd1 << IB) - 32'd1);
        in_range    = (in_set_full < 32'(SETS));
        in_set      = in_range ? IB_W'(in_set_full) : '0;
        in_offset   = OB_W'(in_addr & ((32'd1 << OB) - 32'd1));
        in_tag      = TAG_W'(in_addr >> (OB + IB));
        for (int k = 0; k < BLOCK_WORDS; k++)
        begin
            in_block[k] = in_data[sacbpv_pkg::FILL_LSB + k * WORD_W +: WORD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_op_reg     <= in_user;
            req_range_reg  <= in_range;
            req_set_reg    <= in_set;
            req_offset_reg <= in_offset;
            req_tag_reg    <= in_tag;
            req_bp_reg     <= in_data[sacbpv_pkg::BP_LSB +: BP_W];
            req_block_reg  <= in_block;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_idx_reg <= clr_idx_reg + IB_W'(1);
        end
    end

    assign stat.clear_done = (clr_idx_reg == IB_W'(SETS - 1));

    // Way selection over the registered set row.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            tag_eq[w]     = (rd_tag_reg[w] == req_tag_reg);
            prefix_vec[w] = 1'b1;
            best_vec[w]   = (rd_prio_reg[w] != '0);
            for (int v = 0; v < WAYS; v++)
            begin
                if (v <= w && !rd_valid_reg[v])
                begin
                    prefix_vec[w] = 1'b0;
                end
                // First way holding the strictly greatest priority.
                if (v < w && rd_prio_reg[v] >= rd_prio_reg[w])
                begin
                    best_vec[w] = 1'b0;
                end
                if (v > w && rd_prio_reg[v] > rd_prio_reg[w])
                begin
                    best_vec[w] = 1'b0;
                end
            end
        end
        hit_vec     = rd_valid_reg & tag_eq;
        present_vec = prefix_vec & tag_eq;
        empty_vec   = ~rd_valid_reg;
        hit_oh      = hit_vec & (~hit_vec + WAYS'(1));
        present_oh  = present_vec & (~present_vec + WAYS'(1));
        empty_oh    = empty_vec & (~empty_vec + WAYS'(1));
        best_oh     = best_vec & (~best_vec + WAYS'(1));
        chosen_oh   = (|empty_vec) ? empty_oh : best_oh;
        present_any = |present_vec;
        chosen_any  = |chosen_oh;
        fill_oh     = present_any ? '0 : chosen_oh;
    end

    // New contents of the set row.
    always_comb
    begin
        valid_next = rd_valid_reg | fill_oh;
        for (int w = 0; w < WAYS; w++)
        begin
            tag_next[w]  = fill_oh[w] ? req_tag_reg : rd_tag_reg[w];
            data_next[w] = fill_oh[w] ? req_block_reg : rd_data_reg[w];
            if (fill_oh[w] || (present_oh[w] && req_bp_reg < rd_prio_reg[w]))
            begin
                prio_next[w] = req_bp_reg;
            end
            else
            begin
                prio_next[w] = rd_prio_reg[w];
            end
        end
    end

    // Result of the held request.
    always_comb
    begin
        word_next = '0;
        if (req_op_reg == sacbpv_pkg::OP_READ)
        begin
            status_next = (req_range_reg && |hit_vec) ? sacbpv_pkg::ST_READ_HIT
                                                      : sacbpv_pkg::ST_READ_MISS;
            for (int w = 0; w < WAYS; w++)
            begin
                for (int k = 0; k < BLOCK_WORDS; k++)
                begin
                    if (req_range_reg && hit_oh[w] && req_offset_reg == OB_W'(k))
                    begin
                        word_next = rd_data_reg[w][k];
                    end
                end
            end
        end
        else if (!req_range_reg)
        begin
            status_next = sacbpv_pkg::ST_REJECTED;
        end
        else if (present_any)
        begin
            status_next = sacbpv_pkg::ST_PRESENT;
        end
        else if (chosen_any)
        begin
            status_next = sacbpv_pkg::ST_FILLED;
        end
        else
        begin
            status_next = sacbpv_pkg::ST_REJECTED;
        end
    end

    assign row_we      = cmd.commit && (req_op_reg == sacbpv_pkg::OP_FILL) && req_range_reg
                         && (present_any || chosen_any);
    assign valid_we    = cmd.clear_step || row_we;
    assign wr_set      = cmd.clear_step ? clr_idx_reg : req_set_reg;
    assign valid_wdata = cmd.clear_step ? '0 : valid_next;
    assign rd_en       = cmd.load_req && in_range;

    always_ff @(posedge clk)
    begin
        if (valid_we)
        begin
            valid_mem[wr_set] <= valid_wdata;
        end
        if (row_we)
        begin
            tag_mem[req_set_reg]  <= tag_next;
            prio_mem[req_set_reg] <= prio_next;
            data_mem[req_set_reg] <= data_next;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[in_set];
            rd_tag_reg   <= tag_mem[in_set];
            rd_prio_reg  <= prio_mem[in_set];
            rd_data_reg  <= data_mem[in_set];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg <= status_next;
            out_word_reg   <= word_next;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_word_reg;
    assign out_user      = out_status_reg;

endmodule

/* rtl/core/set_assoc_cache_base_pointer_victim_top.sv */
// Set-associative cache with base-pointer replacement.
// Requests arrive on the s_ channel: s_tuser is the opcode (read a word or
// fill a block); s_tdata carries the word address, the base pointer and the
// four fill words. Each request yields exactly one result on the m_ channel:
// m_tuser is the status code and m_tdata the word returned on a read hit
// (zero for every other outcome).
// An accepted request is registered with its set row; the lookup stage then
// writes the result to the output register, raising m_tvalid, once that
// register is free. A new request is taken only after that: one step reads
// the set row (valid bits, tags, priorities and data of all ways) from the
// set memory, and the next compares the tags, selects the way and, for a
// fill, writes the row back. After reset a clearing pass zeroes the valid
// bits of every set, one set per cycle; s_tready stays low during this pass.
// The result sits in an output register, so when the receiver stalls the
// block still takes the next request; that request then waits in the lookup
// stage, with its write-back held off, until the output register frees up.
module set_assoc_cache_base_pointer_victim_top #(
    parameter int SETS        = sacbpv_pkg::SETS_DEF,
    parameter int WAYS        = sacbpv_pkg::WAYS_DEF,
    parameter int BLOCK_WORDS = sacbpv_pkg::BLOCK_WORDS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // word_address[31:0], base_pointer[36:32], fill_word_0[100:37],
    // fill_word_1[164:101], fill_word_2[228:165], fill_word_3[292:229], zero pad
    input  logic [sacbpv_pkg::IN_DATA_W-1:0]      s_tdata,
    // opcode
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // read_word
    output logic [sacbpv_pkg::OUT_DATA_W-1:0]     m_tdata,
    // status
    output logic [sacbpv_pkg::STATUS_W-1:0]       m_tuser
);

    sacbpv_pkg::dp_cmd_t  cmd;
    sacbpv_pkg::dp_stat_t stat;

    // The controller sequences the clearing pass and each request.
    sacbpv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the set memory, the way selection and the output register.
    sacbpv_dp #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .BLOCK_WORDS (BLOCK_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

/* rtl/core/sacbpv_chk.sv */
module sacbpv_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [sacbpv_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [sacbpv_pkg::STATUS_W-1:0]   m_tuser
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only the defined status codes ever leave the block.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == sacbpv_pkg::ST_READ_HIT || m_tuser == sacbpv_pkg::ST_READ_MISS
                      || m_tuser == sacbpv_pkg::ST_PRESENT || m_tuser == sacbpv_pkg::ST_FILLED
                      || m_tuser == sacbpv_pkg::ST_REJECTED))
        else $error("undefined status code");

    // Every outcome other than a read hit returns a zero word.
    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != sacbpv_pkg::ST_READ_HIT |-> m_tdata == '0)
        else $error("non-zero word without a read hit");

    // The next request is not taken in the cycle after one is accepted.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken during lookup");

    // With the output empty, a taken request's result reaches the output register without a stall.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |-> ##2 m_tvalid)
        else $error("result missing two cycles after request");

endmodule

bind set_assoc_cache_base_pointer_victim_top sacbpv_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* verif/set_assoc_cache_base_pointer_victim_top_test.sv */
// Testbench for the set-associative cache with base-pointer replacement.
//
// A shadow copy of the cache (valid bits, tags, lowest base pointers and
// block words) is kept here and updated for every request the block
// accepts. That gives the expected status and read word, which are queued
// and compared with each result the block hands out. Directed tests come
// first, then random traffic aimed at a few hot sets so that hits, refills,
// victim choice and rejection all come up often. Both sides of the block
// idle at random. There is a long receiver hold-off and a pause with the
// block fully drained.
module set_assoc_cache_base_pointer_victim_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sacbpv_pkg::*;

    // Geometry as the block is built with its default parameters.
    localparam int OFS_W = $clog2(BLOCK_WORDS_DEF);
    localparam int IDX_W = $clog2(SETS_DEF);
    localparam int TAG_W = ADDR_W - OFS_W - IDX_W;
    localparam int LINES = SETS_DEF * WAYS_DEF;

    // Random traffic concentrates on a handful of sets and tags.
    localparam int HOT_SETS = 4;
    localparam int HOT_TAGS = 6;

    // Length of the receiver hold-off, and the number of cycles without any
    // accepted request or result after which the run is declared hung. The
    // limit covers the clearing pass after reset and the hold-off several
    // times over.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;

    typedef struct packed {
        logic                          op;
        logic [ADDR_W-1:0]             addr;
        logic [BP_W-1:0]               bp;
        logic [FILL_WORDS-1:0][WORD_W-1:0] fill;
    } cache_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   word;
    } cache_rsp_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // Shadow of the cache contents.
    logic                                     shadow_valid [LINES];
    logic [TAG_W-1:0]                         shadow_tag   [LINES];
    logic [BP_W-1:0]                          shadow_prio  [LINES];
    logic [BLOCK_WORDS_DEF-1:0][WORD_W-1:0]   shadow_block [LINES];

    // Results still owed by the block, oldest first.
    cache_rsp_t pending_results [$];

    // Hot sets and tags for the random traffic.
    int               hot_set [HOT_SETS];
    logic [TAG_W-1:0] hot_tag [HOT_SETS][HOT_TAGS];

    int  fault_count;
    int  sent_count;
    int  directed_count;
    int  status_tally [5];
    int  quiet_cycles;
    bit  steady_feed;
    bit  steady_drain;
    bit  hold_off_req;

    set_assoc_cache_base_pointer_victim_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Applies one request to the shadow cache and returns the result the
    // block must give for it. A read returns the addressed word of the first
    // valid way whose tag matches. A fill scans the ways in order and stops at
    // a tag match (lowering that line's priority when the new base pointer is
    // smaller) or at the first invalid way. While scanning it remembers the
    // first valid way with the strictly greatest nonzero priority, which is
    // the victim when the set is full. With no victim the fill is rejected.
    function automatic cache_rsp_t shadow_access(input cache_req_t rq);
        int         ofs;
        int         idx;
        int         slot;
        int         empty_way;
        int         victim_way;
        int         chosen;
        int         best;
        bit         done;
        bit         present;
        logic [TAG_W-1:0] tg;
        cache_rsp_t rs;
        ofs        = int'(rq.addr[OFS_W-1:0]);
        idx        = int'(rq.addr[OFS_W +: IDX_W]);
        tg         = rq.addr[ADDR_W-1:OFS_W+IDX_W];
        rs.word    = '0;
        empty_way  = -1;
        victim_way = -1;
        best       = 0;
        done       = 1'b0;
        present    = 1'b0;
        if (rq.op == OP_READ)
        begin
            rs.status = ST_READ_MISS;
            for (int w = 0; w < WAYS_DEF && !done; w++)
            begin
                slot = idx * WAYS_DEF + w;
                if (shadow_valid[slot] && shadow_tag[slot] == tg)
                begin
                    rs.status = ST_READ_HIT;
                    rs.word   = shadow_block[slot][ofs];
                    done      = 1'b1;
                end
            end
        end
        else
        begin
            rs.status = ST_REJECTED;
            for (int w = 0; w < WAYS_DEF && !done; w++)
            begin
                slot = idx * WAYS_DEF + w;
                if (!shadow_valid[slot])
                begin
                    empty_way = w;
                    done      = 1'b1;
                end
                else if (shadow_tag[slot] == tg)
                begin
                    if (rq.bp < shadow_prio[slot])
                        shadow_prio[slot] = rq.bp;
                    present = 1'b1;
                    done    = 1'b1;
                end
                else if (int'(shadow_prio[slot]) > best)
                begin
                    best       = int'(shadow_prio[slot]);
                    victim_way = w;
                end
            end
            if (present)
                rs.status = ST_PRESENT;
            else
            begin
                chosen = (empty_way >= 0) ? empty_way : victim_way;
                if (chosen >= 0)
                begin
                    slot               = idx * WAYS_DEF + chosen;
                    shadow_valid[slot] = 1'b1;
                    shadow_tag[slot]   = tg;
                    shadow_prio[slot]  = rq.bp;
                    for (int k = 0; k < BLOCK_WORDS_DEF; k++)
                        shadow_block[slot][k] = rq.fill[k];
                    rs.status = ST_FILLED;
                end
            end
        end
        status_tally[rs.status]++;
        return rs;
    endfunction

    function automatic logic [ADDR_W-1:0] compose_addr(input logic [TAG_W-1:0] tg,
                                                       input int idx, input int ofs);
        logic [IDX_W-1:0] idx_bits;
        logic [OFS_W-1:0] ofs_bits;
        idx_bits = idx[IDX_W-1:0];
        ofs_bits = ofs[OFS_W-1:0];
        return {tg, idx_bits, ofs_bits};
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic cache_req_t read_req(input logic [ADDR_W-1:0] addr);
        cache_req_t rq;
        rq.op   = OP_READ;
        rq.addr = addr;
        // Base pointer and fill words are ignored on a read, so they carry
        // noise.
        rq.bp   = BP_W'($urandom);
        for (int k = 0; k < FILL_WORDS; k++)
            rq.fill[k] = random_word();
        return rq;
    endfunction

    function automatic cache_req_t fill_req(input logic [ADDR_W-1:0] addr,
                                            input logic [BP_W-1:0] bp);
        cache_req_t rq;
        rq.op   = OP_FILL;
        rq.addr = addr;
        rq.bp   = bp;
        for (int k = 0; k < FILL_WORDS; k++)
            rq.fill[k] = random_word();
        return rq;
    endfunction

    // Mostly reads and fills on the hot sets, with a tenth of the requests
    // drawn over the whole address space. Base pointers lean towards the
    // extremes so that lines reach priority zero and fills start to bounce.
    function automatic cache_req_t random_request();
        cache_req_t rq;
        int         s;
        int         roll;
        logic [ADDR_W-1:0] addr;
        s    = $urandom_range(0, HOT_SETS - 1);
        addr = compose_addr(hot_tag[s][$urandom_range(0, HOT_TAGS - 1)], hot_set[s],
                            $urandom_range(0, BLOCK_WORDS_DEF - 1));
        if ($urandom_range(0, 9) == 0)
            addr = $urandom;
        if ($urandom_range(0, 99) < 45)
            rq = fill_req(addr, BP_W'($urandom));
        else
            rq = read_req(addr);
        roll = $urandom_range(0, 99);
        if (rq.op == OP_FILL && roll < 12)
            rq.bp = '0;
        else if (rq.op == OP_FILL && roll < 20)
            rq.bp = '1;
        return rq;
    endfunction

    // Offers one request and waits for the block to take it. The valid line
    // is only lowered when an idle gap is inserted, so back-to-back requests
    // keep it high without a glitch.
    task automatic issue_request(input cache_req_t rq);
        logic [IN_DATA_W-1:0] bus;
        if (!steady_feed && $urandom_range(0, 99) < 40)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        bus                            = '0;
        bus[ADDR_LSB +: ADDR_W]        = rq.addr;
        bus[BP_LSB +: BP_W]            = rq.bp;
        bus[FILL_LSB +: FILL_WORDS * WORD_W] = rq.fill;
        s_tvalid <= 1'b1;
        s_tdata  <= bus;
        s_tuser  <= rq.op;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results = {pending_results, shadow_access(rq)};
        sent_count++;
    endtask

    // Stops offering requests until every owed result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Reads at both ends of the address space into the empty cache.
    task automatic test_cold_reads();
        issue_request(read_req('0));
        issue_request(read_req('1));
    endtask

    // Fills at both address extremes, one with all-ones data and the
    // greatest base pointer, one with zero data and base pointer zero, and
    // reads each back.
    task automatic test_extreme_fills();
        cache_req_t rq;
        rq = fill_req('1, '1);
        for (int k = 0; k < FILL_WORDS; k++)
            rq.fill[k] = '1;
        issue_request(rq);
        issue_request(read_req('1));
        rq = fill_req('0, '0);
        rq.fill = '0;
        issue_request(rq);
        issue_request(read_req('0));
    endtask

    // Fills all four ways of one set with distinct base pointers, then reads
    // every word of the first line.
    task automatic test_set_fill_and_hits();
        issue_request(fill_req(compose_addr(24'h00_0A01, 5, 0), 5'd10));
        issue_request(fill_req(compose_addr(24'h00_0B02, 5, 1), 5'd20));
        issue_request(fill_req(compose_addr(24'h00_0C03, 5, 2), 5'd31));
        issue_request(fill_req(compose_addr(24'h00_0D04, 5, 3), 5'd5));
        for (int ofs = 0; ofs < BLOCK_WORDS_DEF; ofs++)
            issue_request(read_req(compose_addr(24'h00_0A01, 5, ofs)));
    endtask

    // A fill of a tag already present: a larger base pointer leaves the
    // line alone, a smaller one lowers its priority.
    task automatic test_already_present();
        issue_request(fill_req(compose_addr(24'h00_0B02, 5, 0), 5'd25));
        issue_request(fill_req(compose_addr(24'h00_0B02, 5, 2), 5'd7));
    endtask

    // With the set full, the line with the greatest priority is evicted,
    // first the one at 31 and then the one at 10. The evicted tag must then
    // miss and the new one hit.
    task automatic test_victim_choice();
        issue_request(fill_req(compose_addr(24'h00_0E05, 5, 0), 5'd3));
        issue_request(fill_req(compose_addr(24'h00_0F06, 5, 0), 5'd0));
        issue_request(read_req(compose_addr(24'h00_0C03, 5, 1)));
        issue_request(read_req(compose_addr(24'h00_0F06, 5, 3)));
    endtask

    // Set zero filled only with base pointer zero leaves no victim, so the
    // fifth tag is rejected.
    task automatic test_no_victim_reject();
        for (int t = 1; t <= WAYS_DEF; t++)
            issue_request(fill_req(compose_addr(TAG_W'(t), 0, 0), '0));
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++)
            issue_request(random_request());
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the output register and the lookup stage fill and the input stalls.
    task automatic test_output_hold_off(input int count);
        steady_feed  = 1'b1;
        hold_off_req = 1'b1;
        test_random_traffic(count);
        steady_feed  = 1'b0;
    endtask

    // Full rate on both sides: no idle gaps from the sender, the receiver always ready.
    task automatic test_steady_stream(input int count);
        steady_feed  = 1'b1;
        steady_drain = 1'b1;
        test_random_traffic(count);
        steady_feed  = 1'b0;
        steady_drain = 1'b0;
    endtask

    // Receiver: random stalls, a long hold-off when asked for one, or always
    // ready during the steady stretch.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (steady_drain)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 28);
        end
    end

    // Compares each result with the oldest one still owed.
    always @(posedge clk)
    begin
        cache_rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none owed: status %0d, read_word %h", m_tuser, m_tdata);
                fault_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
                    fault_count++;
                end
                if (m_tdata !== want.word)
                begin
                    $error("read_word mismatch: expected %h, got %h", want.word, m_tdata);
                    fault_count++;
                end
            end
        end
    end

    // Ends a hung run: nothing accepted on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles, %0d results owed",
                     quiet_cycles, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_READ;
        rst_n        = 1'b0;
        fault_count  = 0;
        sent_count   = 0;
        quiet_cycles = 0;
        steady_feed  = 1'b0;
        steady_drain = 1'b0;
        hold_off_req = 1'b0;
        for (int i = 0; i < 5; i++)
            status_tally[i] = 0;
        for (int i = 0; i < LINES; i++)
            shadow_valid[i] = 1'b0;
        for (int s = 0; s < HOT_SETS; s++)
        begin
            hot_set[s] = $urandom_range(0, SETS_DEF - 1);
            for (int t = 0; t < HOT_TAGS; t++)
                hot_tag[s][t] = TAG_W'($urandom);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first request waits out the clearing pass on s_tready.
        test_cold_reads();
        test_extreme_fills();
        test_set_fill_and_hits();
        test_already_present();
        test_victim_choice();
        test_no_victim_reject();
        directed_count = sent_count;

        test_random_traffic(300);
        test_output_hold_off(40);
        wait_drained();
        test_steady_stream(150);
        test_random_traffic(260);

        // Let the last results through, then allow a few more cycles for
        // any stray result to show up.
        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            fault_count++;
        end

        $display("Ran %0d requests (%0d directed) with random stalls, a long hold-off and a drain.",
                 sent_count, directed_count);
        $display("Outcomes: %0d hits, %0d misses, %0d present, %0d filled, %0d rejected.",
                 status_tally[ST_READ_HIT], status_tally[ST_READ_MISS],
                 status_tally[ST_PRESENT], status_tally[ST_FILLED],
                 status_tally[ST_REJECTED]);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
